@@ src/assert_macros.svh @@
// Assertion macros for the picker RTL; included by fnrp_back.
// Depends on nothing; users supply clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Concurrent property, checked on clk_i, off while rst_ni is low.
`define FNRP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Condition that must never hold.
`define FNRP_NEVER(label, cond, msg) \
  `FNRP_ASSERT(label, !(cond), msg)
`else
`define FNRP_ASSERT(label, prop, msg)
`define FNRP_NEVER(label, cond, msg)
`endif

`endif

@@ src/fnrp_pkg.sv @@
// Types and constants for the font name record picker.
// No dependencies; used by every module of the block but fnrp_fifo.
package fnrp_pkg;

  // One record of the name table.
  typedef struct packed {
    logic [15:0] platform_id;
    logic [15:0] encoding_id;
    logic [15:0] language_id;
    logic [15:0] record_name_id;
    logic [15:0] string_length;
    logic [15:0] string_offset;
    logic        last_record;
  } rec_t;

  // One result, sent after the last record of a table.
  typedef struct packed {
    logic        found;
    logic [15:0] record_index;
    logic        is_utf16;
  } res_t;

  // Record class as decided by the front part.
  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_UNI,
    KIND_MAC_ENG,
    KIND_MAC_ROMAN,
    KIND_WIN
  } kind_e;

  // Classified record, passed from front to back.
  typedef struct packed {
    kind_e       kind;
    logic        win_english;
    logic [15:0] index;
    logic        last_record;
  } cls_t;

  // A kept candidate.
  typedef struct packed {
    logic        valid;
    logic [15:0] index;
  } pick_t;

  localparam logic [15:0] PLAT_UNICODE   = 16'd0;
  localparam logic [15:0] PLAT_MAC       = 16'd1;
  localparam logic [15:0] PLAT_ISO       = 16'd2;
  localparam logic [15:0] PLAT_MICROSOFT = 16'd3;

  localparam logic [15:0] ENC_MAC_ROMAN  = 16'd0;
  localparam logic [15:0] ENC_MS_SYMBOL  = 16'd0;
  localparam logic [15:0] ENC_MS_UNICODE = 16'd1;
  localparam logic [15:0] ENC_MS_UCS4    = 16'd10;

  localparam logic [15:0] LANG_MAC_ENGLISH = 16'd0;
  localparam logic [9:0]  LANG_MASK        = 10'h3FF;
  localparam logic [9:0]  LANG_MS_ENGLISH  = 10'h009;

endpackage

@@ src/fnrp_fifo.sv @@
// Small first-in first-out queue of flat words.
// No package dependency; used for the record and result queues.
module fnrp_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

@@ src/fnrp_front.sv @@
// Front part: numbers records, checks string bounds and classifies them.
// Depends on fnrp_pkg.
module fnrp_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  fnrp_pkg::rec_t     rec_i,
  input  logic [15:0]        wanted_name_id_i,
  input  logic [15:0]        storage_offset_i,
  input  logic [19:0]        records_end_i,
  input  logic [30:0]        table_length_i,
  output fnrp_pkg::cls_t     cls_o
);

  logic [15:0] count_q, count_d;
  logic [16:0] str_start;
  logic [17:0] str_end;
  logic        in_storage, hit, win_enc_ok;

  assign str_start = {1'b0, storage_offset_i} + {1'b0, rec_i.string_offset};
  assign str_end   = {1'b0, str_start} + {2'b0, rec_i.string_length};

  assign in_storage = (rec_i.string_length != '0)
                   && ({3'b0, str_start} >= records_end_i)
                   && ({14'b0, str_start} <= table_length_i)
                   && ({13'b0, str_end} <= table_length_i);

  assign hit = in_storage && (rec_i.record_name_id == wanted_name_id_i);

  assign win_enc_ok = (rec_i.encoding_id == fnrp_pkg::ENC_MS_SYMBOL)
                   || (rec_i.encoding_id == fnrp_pkg::ENC_MS_UNICODE)
                   || (rec_i.encoding_id == fnrp_pkg::ENC_MS_UCS4);

  always_comb begin
    cls_o.kind        = fnrp_pkg::KIND_NONE;
    cls_o.win_english = (rec_i.language_id[9:0] & fnrp_pkg::LANG_MASK)
                        == fnrp_pkg::LANG_MS_ENGLISH;
    cls_o.index       = count_q;
    cls_o.last_record = rec_i.last_record;
    if (hit) begin
      case (rec_i.platform_id)
        fnrp_pkg::PLAT_UNICODE, fnrp_pkg::PLAT_ISO: begin
          cls_o.kind = fnrp_pkg::KIND_UNI;
        end
        fnrp_pkg::PLAT_MAC: begin
          if (rec_i.language_id == fnrp_pkg::LANG_MAC_ENGLISH) begin
            cls_o.kind = fnrp_pkg::KIND_MAC_ENG;
          end else if (rec_i.encoding_id == fnrp_pkg::ENC_MAC_ROMAN) begin
            cls_o.kind = fnrp_pkg::KIND_MAC_ROMAN;
          end
        end
        fnrp_pkg::PLAT_MICROSOFT: begin
          if (win_enc_ok) begin
            cls_o.kind = fnrp_pkg::KIND_WIN;
          end
        end
        default: begin
          cls_o.kind = fnrp_pkg::KIND_NONE;
        end
      endcase
    end
  end

  // Advance per record, restart after the last one.
  always_comb begin
    count_d = count_q;
    if (accept_i) begin
      count_d = rec_i.last_record ? '0 : count_q + 16'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule

@@ src/fnrp_back.sv @@
// Back part: keeps the candidate picks and forms the result per table.
// Depends on fnrp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fnrp_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  fnrp_pkg::cls_t cls_i,
  input  logic           cls_valid_i,
  output logic           cls_pop_o,
  output fnrp_pkg::res_t res_o,
  output logic           res_push_o,
  input  logic           res_full_i
);

  fnrp_pkg::pick_t eng_q, eng_d, rom_q, rom_d, win_q, win_d, uni_q, uni_d;
  fnrp_pkg::pick_t mac_sel, cur_pick;
  logic            win_eng_q, win_eng_d;
  logic            take;

  // Hold a last record while the result queue has no room.
  assign take       = cls_valid_i && (!cls_i.last_record || !res_full_i);
  assign cls_pop_o  = take;
  assign res_push_o = take && cls_i.last_record;
  assign cur_pick   = '{valid: 1'b1, index: cls_i.index};

  always_comb begin
    eng_d     = eng_q;
    rom_d     = rom_q;
    win_d     = win_q;
    uni_d     = uni_q;
    win_eng_d = win_eng_q;
    if (take) begin
      case (cls_i.kind)
        fnrp_pkg::KIND_UNI:       uni_d = cur_pick;
        fnrp_pkg::KIND_MAC_ENG:   eng_d = cur_pick;
        fnrp_pkg::KIND_MAC_ROMAN: rom_d = cur_pick;
        fnrp_pkg::KIND_WIN: begin
          if (!win_q.valid || cls_i.win_english) begin
            win_d     = cur_pick;
            win_eng_d = cls_i.win_english;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    mac_sel = eng_d.valid ? eng_d : rom_d;
    res_o   = '0;
    if (win_d.valid && !(mac_sel.valid && !win_eng_d)) begin
      res_o = '{found: 1'b1, record_index: win_d.index, is_utf16: 1'b1};
    end else if (mac_sel.valid) begin
      res_o = '{found: 1'b1, record_index: mac_sel.index, is_utf16: 1'b0};
    end else if (uni_d.valid) begin
      res_o = '{found: 1'b1, record_index: uni_d.index, is_utf16: 1'b1};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eng_q     <= '0;
      rom_q     <= '0;
      win_q     <= '0;
      uni_q     <= '0;
      win_eng_q <= 1'b0;
    end else if (res_push_o) begin
      eng_q     <= '0;
      rom_q     <= '0;
      win_q     <= '0;
      uni_q     <= '0;
      win_eng_q <= 1'b0;
    end else begin
      eng_q     <= eng_d;
      rom_q     <= rom_d;
      win_q     <= win_d;
      uni_q     <= uni_d;
      win_eng_q <= win_eng_d;
    end
  end

  `FNRP_ASSERT(a_clear_after_last, res_push_o |=> (!eng_q.valid && !rom_q.valid && !win_q.valid && !uni_q.valid && !win_eng_q), "picks not cleared after table end")
  `FNRP_ASSERT(a_none_is_zero, (res_push_o && !res_o.found) |-> (res_o.record_index == '0 && !res_o.is_utf16), "empty result carries data")
  `FNRP_ASSERT(a_win_sticky, (win_q.valid && !take) |=> (win_q.valid && win_q.index == $past(win_q.index)), "windows pick moved while idle")
  `FNRP_NEVER(a_utf16_source, res_push_o && res_o.found && res_o.is_utf16 && !win_d.valid && !uni_d.valid, "utf16 result without a utf16 pick")
  `FNRP_NEVER(a_mac_source, res_push_o && res_o.found && !res_o.is_utf16 && !eng_d.valid && !rom_d.valid, "mac result without a mac pick")

endmodule

@@ src/font_name_record_picker.sv @@
// Top level of the font name record picker: config registers and queues.
// Depends on fnrp_pkg, fnrp_fifo, fnrp_front and fnrp_back.
// Usage:
//  - Records of one name table go in one item at a time on rec_i (push/full),
//    numbered from 0 in arrival order. The item with last_record set closes
//    the table and makes exactly one result item; other records make none.
//  - Results leave on res_o (empty/pop): found, the chosen record index and
//    whether the chosen string is UTF-16.
//  - Registers sit on the APB port: 0x0 wanted name id, 0x4 string storage
//    offset, 0x8 end of record array, 0xC table length. Write them only
//    while no table is in flight.
// Path: a last record is registered in the record queue, then its result is
//   registered in the result queue (empty low) when the result side is free.
// Throughput: one record per cycle when not stalled, set by the single pick
//   update in the back part; front and back each take one item per cycle.
// Reset: registers go to their reset values, queues empty, record count and
//   all picks cleared. No clearing pass is needed.
// Stall: while pop is low, results fill the result queue (ResultDepth); the
//   next last record then waits in the record queue (QueueDepth), and full
//   rises once that queue is full. Non-last records keep flowing until then.
module font_name_record_picker #(
  parameter int QueueDepth  = 2,
  parameter int ResultDepth = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  // record channel
  input  logic           push,
  output logic           full,
  input  fnrp_pkg::rec_t rec_i,
  // result channel
  output logic           empty,
  input  logic           pop,
  output fnrp_pkg::res_t res_o,
  // configuration port
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [3:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  // register numbers, taken from paddr[3:2]
  localparam logic [1:0] REG_WANTED_ID   = 2'd0;
  localparam logic [1:0] REG_STORAGE_OFS = 2'd1;
  localparam logic [1:0] REG_RECORDS_END = 2'd2;
  localparam logic [1:0] REG_TABLE_LEN   = 2'd3;

  logic [15:0] wanted_q;
  logic [15:0] storage_ofs_q;
  logic [19:0] records_end_q;
  logic [30:0] table_len_q;
  logic        cfg_wr;

  fnrp_pkg::cls_t cls_front, cls_back;
  logic           mid_full, mid_empty, mid_pop, rec_accept;
  fnrp_pkg::res_t res_back;
  logic           res_push, res_full;

  // ---------------------------------------------------------------------
  // Configuration registers: zero wait states, word index from paddr[3:2].
  // ---------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wanted_q      <= 16'd1;
      storage_ofs_q <= 16'd0;
      records_end_q <= 20'd6;
      table_len_q   <= 31'd0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_WANTED_ID:   wanted_q      <= pwdata[15:0];
        REG_STORAGE_OFS: storage_ofs_q <= pwdata[15:0];
        REG_RECORDS_END: records_end_q <= pwdata[19:0];
        REG_TABLE_LEN:   table_len_q   <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_WANTED_ID:   prdata = {16'b0, wanted_q};
      REG_STORAGE_OFS: prdata = {16'b0, storage_ofs_q};
      REG_RECORDS_END: prdata = {12'b0, records_end_q};
      REG_TABLE_LEN:   prdata = {1'b0, table_len_q};
      default:         prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Front: take a record whenever the record queue has room.
  // ---------------------------------------------------------------------
  assign full       = mid_full;
  assign rec_accept = push && !mid_full;

  fnrp_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (rec_accept),
    .rec_i            (rec_i),
    .wanted_name_id_i (wanted_q),
    .storage_offset_i (storage_ofs_q),
    .records_end_i    (records_end_q),
    .table_length_i   (table_len_q),
    .cls_o            (cls_front)
  );

  // Classified records wait here so front and back stall independently.
  fnrp_fifo #(
    .Width ($bits(fnrp_pkg::cls_t)),
    .Depth (QueueDepth)
  ) u_rec_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (cls_front),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .rdata_o (cls_back),
    .empty_o (mid_empty)
  );

  // ---------------------------------------------------------------------
  // Back: update picks, emit a result on the last record.
  // ---------------------------------------------------------------------
  fnrp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cls_i       (cls_back),
    .cls_valid_i (!mid_empty),
    .cls_pop_o   (mid_pop),
    .res_o       (res_back),
    .res_push_o  (res_push),
    .res_full_i  (res_full)
  );

  // Results wait here until the receiver pops them.
  fnrp_fifo #(
    .Width ($bits(fnrp_pkg::res_t)),
    .Depth (ResultDepth)
  ) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_back),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_o),
    .empty_o (empty)
  );

endmodule

@@ test/font_name_record_picker_test.sv @@
// Self-checking testbench for font_name_record_picker: drives name table records
// and APB register writes, and predicts the chosen record per table.
// Depends on fnrp_pkg and the font_name_record_picker RTL only.
module font_name_record_picker_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Register map order; byte address is four times the index.
  typedef enum int {
    REG_NAME_ID,
    REG_STORAGE_OFF,
    REG_RECORDS_END,
    REG_TABLE_LEN
  } reg_e;

  // Result-side stall patterns.
  typedef enum int {
    POP_ALWAYS,
    POP_MOSTLY,
    POP_RARELY,
    POP_LONG_STALL
  } pop_mode_e;

  localparam logic [15:0] DIR_NAME_ID  = 16'd5;
  localparam int unsigned PHASE_COUNT  = 12;
  localparam int unsigned PHASE_ITEMS  = 85;
  // Cycles to let the block settle after the last result.
  localparam int unsigned SETTLE       = 6;

  // Tracks the picks of the table in flight and holds the chosen records
  // still to come out of the block.
  class table_pick_board;
    logic [15:0]     wanted_id;
    logic [15:0]     storage_off;
    logic [19:0]     rec_end;
    logic [30:0]     tab_len;
    logic [15:0]     rec_count;
    fnrp_pkg::pick_t mac_eng, mac_roman, win, uni;
    logic            win_english;
    fnrp_pkg::res_t  expected_picks[$];
    int unsigned     errors, tables, found_tables, records;

    function new();
      wanted_id   = 16'd1;
      storage_off = '0;
      rec_end     = 20'd6;
      tab_len     = '0;
      errors      = 0;
      clear_table();
    endfunction

    function void clear_table();
      rec_count   = '0;
      mac_eng     = '0;
      mac_roman   = '0;
      win         = '0;
      uni         = '0;
      win_english = 1'b0;
    endfunction

    function void set_reg(reg_e idx, logic [31:0] val);
      case (idx)
        REG_NAME_ID:     wanted_id   = val[15:0];
        REG_STORAGE_OFF: storage_off = val[15:0];
        REG_RECORDS_END: rec_end     = val[19:0];
        default:         tab_len     = val[30:0];
      endcase
    endfunction

    function logic [31:0] reg_value(reg_e idx);
      case (idx)
        REG_NAME_ID:     return {16'd0, wanted_id};
        REG_STORAGE_OFF: return {16'd0, storage_off};
        REG_RECORDS_END: return {12'd0, rec_end};
        default:         return {1'b0, tab_len};
      endcase
    endfunction

    // Non-empty string lying wholly in [records end, table length).
    function bit string_fits(logic [15:0] len, logic [15:0] off);
      int unsigned start;
      start = storage_off + off;
      if (len == 0) return 1'b0;
      if (start < rec_end) return 1'b0;
      if (start > tab_len) return 1'b0;
      if (len > tab_len - start) return 1'b0;
      return 1'b1;
    endfunction

    function void note_record(fnrp_pkg::rec_t r);
      fnrp_pkg::pick_t here;
      fnrp_pkg::pick_t mac;
      logic            eng;
      fnrp_pkg::res_t  res;
      here = '{valid: 1'b1, index: rec_count};
      records++;
      if (string_fits(r.string_length, r.string_offset) &&
          r.record_name_id == wanted_id) begin
        case (r.platform_id)
          fnrp_pkg::PLAT_UNICODE, fnrp_pkg::PLAT_ISO: uni = here;
          fnrp_pkg::PLAT_MAC: begin
            if (r.language_id == fnrp_pkg::LANG_MAC_ENGLISH) mac_eng = here;
            else if (r.encoding_id == fnrp_pkg::ENC_MAC_ROMAN) mac_roman = here;
          end
          fnrp_pkg::PLAT_MICROSOFT: begin
            eng = (r.language_id[9:0] & fnrp_pkg::LANG_MASK) == fnrp_pkg::LANG_MS_ENGLISH;
            if ((!win.valid || eng) &&
                (r.encoding_id == fnrp_pkg::ENC_MS_SYMBOL ||
                 r.encoding_id == fnrp_pkg::ENC_MS_UNICODE ||
                 r.encoding_id == fnrp_pkg::ENC_MS_UCS4)) begin
              win_english = eng;
              win         = here;
            end
          end
          default: ;
        endcase
      end
      rec_count++;
      if (r.last_record) begin
        mac = mac_eng.valid ? mac_eng : mac_roman;
        res = '0;
        if (win.valid && !(mac.valid && !win_english))
          res = '{found: 1'b1, record_index: win.index, is_utf16: 1'b1};
        else if (mac.valid)
          res = '{found: 1'b1, record_index: mac.index, is_utf16: 1'b0};
        else if (uni.valid)
          res = '{found: 1'b1, record_index: uni.index, is_utf16: 1'b1};
        expected_picks.push_back(res);
        tables++;
        if (res.found) found_tables++;
        clear_table();
      end
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got, bit known);
      if (!known || want != got) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(fnrp_pkg::res_t got);
      fnrp_pkg::res_t want;
      if (expected_picks.size() == 0) begin
        $display("%0t: result with none expected: found %0b index %0d utf16 %0b",
                 $time, got.found, got.record_index, got.is_utf16);
        errors++;
        return;
      end
      want = expected_picks.pop_front();
      compare_field("found", want.found, got.found, !$isunknown(got.found));
      compare_field("record_index", want.record_index, got.record_index,
                    !$isunknown(got.record_index));
      compare_field("is_utf16", want.is_utf16, got.is_utf16, !$isunknown(got.is_utf16));
    endfunction
  endclass

  logic           clk_i;
  logic           rst_ni;
  logic           push;
  logic           full;
  fnrp_pkg::rec_t rec_i;
  logic           empty;
  logic           pop;
  fnrp_pkg::res_t res_o;
  logic           psel;
  logic           penable;
  logic           pwrite;
  logic [3:0]     paddr;
  logic [31:0]    pwdata;
  logic [31:0]    prdata;
  logic           pready;

  table_pick_board picks = new();

  int unsigned burst_left = 0;
  int unsigned phases_run = 0;
  pop_mode_e   pop_mode   = POP_ALWAYS;
  int unsigned mode_left  = 0;
  int unsigned hold_left  = 0;

  font_name_record_picker u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push    (push),
    .full    (full),
    .rec_i   (rec_i),
    .empty   (empty),
    .pop     (pop),
    .res_o   (res_o),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Sample both handshakes at the rising edge. Check the result first so a
  // record accepted on the same edge can never satisfy it.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) picks.check_result(res_o);
      if (push && !full) picks.note_record(rec_i);
    end
  end

  // Result side: switch stall pattern at random intervals, including
  // stretches of steady popping and long holds that back the block up.
  always @(negedge clk_i) begin
    if (mode_left == 0) begin
      pop_mode  = pop_mode_e'($urandom_range(0, 3));
      mode_left = $urandom_range(40, 200);
    end
    mode_left--;
    case (pop_mode)
      POP_ALWAYS: pop <= 1'b1;
      POP_MOSTLY: pop <= ($urandom_range(0, 3) != 0);
      POP_RARELY: pop <= ($urandom_range(0, 3) == 0);
      default: begin
        if (hold_left == 0) hold_left = $urandom_range(1, 24);
        hold_left--;
        pop <= (hold_left == 0);
      end
    endcase
  end

  // Write one register: setup cycle, then access cycle until pready.
  task automatic apb_write(reg_e idx, logic [31:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 4'(idx * 4);
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    picks.set_reg(idx, val);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Read one register back and compare it with the value last written.
  task automatic apb_read(reg_e idx);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= 4'(idx * 4);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== picks.reg_value(idx)) begin
      $display("%0t: register %s read, expected 0x%08h, got 0x%08h",
               $time, idx.name(), picks.reg_value(idx), prdata);
      picks.errors++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Program all four registers and read them back; call only while idle.
  task automatic set_config(logic [15:0] name_id, logic [15:0] soff,
                            logic [19:0] rend, logic [30:0] tlen);
    apb_write(REG_NAME_ID, {16'd0, name_id});
    apb_write(REG_STORAGE_OFF, {16'd0, soff});
    apb_write(REG_RECORDS_END, {12'd0, rend});
    apb_write(REG_TABLE_LEN, {1'b0, tlen});
    for (int i = 0; i < 4; i++) apb_read(reg_e'(i));
    phases_run++;
  endtask

  // Offer one record; insert a random gap between bursts, then hold push
  // until the block takes the item.
  task automatic send_record(fnrp_pkg::rec_t r);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk_i);
        push <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk_i);
    push  <= 1'b1;
    rec_i <= r;
    do @(posedge clk_i); while (full);
  endtask

  // Stop sending and wait for every pending pick, then let the block settle.
  task automatic drain_picks();
    @(negedge clk_i);
    push <= 1'b0;
    burst_left = 0;
    while (picks.expected_picks.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  function automatic fnrp_pkg::rec_t mk(logic [15:0] plat, logic [15:0] enc,
                                        logic [15:0] lang, logic [15:0] name_id,
                                        logic [15:0] len, logic [15:0] off,
                                        logic last);
    return '{platform_id: plat, encoding_id: enc, language_id: lang,
             record_name_id: name_id, string_length: len, string_offset: off,
             last_record: last};
  endfunction

  // Random record, mostly well formed for the current registers: wanted
  // name id and a string placed inside storage, often right at its edges.
  function automatic fnrp_pkg::rec_t make_record(logic last);
    fnrp_pkg::rec_t r;
    int unsigned    lo, hi, start, room;
    case ($urandom_range(0, 9))
      0:       r.platform_id = fnrp_pkg::PLAT_UNICODE;
      1:       r.platform_id = fnrp_pkg::PLAT_ISO;
      2, 3, 4: r.platform_id = fnrp_pkg::PLAT_MAC;
      5, 6, 7: r.platform_id = fnrp_pkg::PLAT_MICROSOFT;
      8:       r.platform_id = 16'($urandom_range(4, 15));
      default: r.platform_id = 16'($urandom);
    endcase
    if (r.platform_id == fnrp_pkg::PLAT_MICROSOFT) begin
      case ($urandom_range(0, 4))
        0:       r.encoding_id = fnrp_pkg::ENC_MS_SYMBOL;
        1, 2:    r.encoding_id = fnrp_pkg::ENC_MS_UNICODE;
        3:       r.encoding_id = fnrp_pkg::ENC_MS_UCS4;
        default: r.encoding_id = 16'($urandom);
      endcase
      case ($urandom_range(0, 3))
        0:       r.language_id = 16'h0409;
        1:       r.language_id = {6'($urandom), fnrp_pkg::LANG_MS_ENGLISH};
        default: r.language_id = 16'($urandom);
      endcase
    end else begin
      r.encoding_id = ($urandom_range(0, 1) == 0) ? fnrp_pkg::ENC_MAC_ROMAN
                                                  : 16'($urandom);
      r.language_id = ($urandom_range(0, 2) == 0) ? fnrp_pkg::LANG_MAC_ENGLISH
                                                  : 16'($urandom);
    end
    r.record_name_id = ($urandom_range(0, 4) != 0) ? picks.wanted_id : 16'($urandom);

    lo = (picks.rec_end > picks.storage_off) ? picks.rec_end : picks.storage_off;
    hi = picks.storage_off + 32'hFFFF;
    if (picks.tab_len != 0 && picks.tab_len - 1 < hi) hi = picks.tab_len - 1;
    if (picks.tab_len != 0 && lo <= hi && $urandom_range(0, 4) != 0) begin
      case ($urandom_range(0, 3))
        0:       start = lo;
        1:       start = hi;
        default: start = $urandom_range(lo, hi);
      endcase
      room = picks.tab_len - start;
      if (room > 32'hFFFF) room = 32'hFFFF;
      r.string_offset = 16'(start - picks.storage_off);
      case ($urandom_range(0, 5))
        0:       r.string_length = 16'(room);
        1:       r.string_length = 16'((room < 32'hFFFF) ? room + 1 : room);
        2:       r.string_length = '0;
        default: r.string_length = 16'($urandom_range(1, room));
      endcase
    end else begin
      r.string_offset = 16'($urandom);
      r.string_length = ($urandom_range(0, 5) == 0) ? 16'd0 : 16'($urandom);
    end
    r.last_record = last;
    return r;
  endfunction

  task automatic send_table(int unsigned count);
    for (int unsigned i = 0; i < count; i++) send_record(make_record(i == count - 1));
  endtask

  // Fill a phase with tables of mostly short length, a few long ones.
  task automatic send_tables(int unsigned budget);
    int unsigned sent, count;
    sent = 0;
    while (sent < budget) begin
      count = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 60) : $urandom_range(1, 16);
      send_table(count);
      sent += count;
    end
  endtask

  task automatic random_config();
    logic [19:0] rend;
    rend = 20'($urandom_range(6, 2000));
    set_config(($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 7)),
               16'($urandom_range(0, 2500)), rend,
               31'(rend + $urandom_range(0, 80000)));
  endtask

  initial begin
    fnrp_pkg::rec_t directed[$];
    rst_ni  = 1'b0;
    push    = 1'b0;
    rec_i   = '0;
    pop     = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed tables. Storage spans [50, 1000), string start is 20 + offset.
    set_config(DIR_NAME_ID, 16'd20, 20'd50, 31'd1000);
    // English Windows beats Mac English; a later non-English Windows record
    // does not replace it; an all-ones last record is ignored.
    directed.push_back(mk(fnrp_pkg::PLAT_MAC, fnrp_pkg::ENC_MAC_ROMAN,
                          fnrp_pkg::LANG_MAC_ENGLISH, DIR_NAME_ID, 10, 100, 0));
    directed.push_back(mk(fnrp_pkg::PLAT_MICROSOFT, fnrp_pkg::ENC_MS_UNICODE,
                          16'h0409, DIR_NAME_ID, 10, 100, 0));
    directed.push_back(mk(fnrp_pkg::PLAT_UNICODE, 0, 0, DIR_NAME_ID, 10, 100, 0));
    directed.push_back(mk(fnrp_pkg::PLAT_MICROSOFT, fnrp_pkg::ENC_MS_UNICODE,
                          16'h0412, DIR_NAME_ID, 10, 100, 0));
    directed.push_back(mk(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1));
    // Mac over non-English Windows: Roman, neither kind, then English wins;
    // unknown platform closes the table.
    directed.push_back(mk(fnrp_pkg::PLAT_MICROSOFT, fnrp_pkg::ENC_MS_UCS4,
                          16'h0412, DIR_NAME_ID, 10, 100, 0));
    directed.push_back(mk(fnrp_pkg::PLAT_MAC, fnrp_pkg::ENC_MAC_ROMAN,
                          16'd5, DIR_NAME_ID, 10, 100, 0));
    directed.push_back(mk(fnrp_pkg::PLAT_MAC, 16'd3, 16'd7, DIR_NAME_ID, 10, 100, 0));
    directed.push_back(mk(fnrp_pkg::PLAT_MAC, 16'd3, fnrp_pkg::LANG_MAC_ENGLISH,
                          DIR_NAME_ID, 10, 100, 0));
    directed.push_back(mk(16'd4, 0, 0, DIR_NAME_ID, 10, 100, 1));
    // Unicode/ISO fallback: empty string, start below storage, start at the
    // table end, end past it, start past it, unsupported encoding, other id.
    directed.push_back(mk(fnrp_pkg::PLAT_ISO, 0, 0, DIR_NAME_ID, 4, 30, 0));
    directed.push_back(mk(fnrp_pkg::PLAT_MICROSOFT, fnrp_pkg::ENC_MS_UNICODE,
                          16'h0409, DIR_NAME_ID, 0, 100, 0));
    directed.push_back(mk(fnrp_pkg::PLAT_MICROSOFT, fnrp_pkg::ENC_MS_UNICODE,
                          16'h0409, DIR_NAME_ID, 4, 29, 0));
    directed.push_back(mk(fnrp_pkg::PLAT_MICROSOFT, fnrp_pkg::ENC_MS_UNICODE,
                          16'h0409, DIR_NAME_ID, 1, 980, 0));
    directed.push_back(mk(fnrp_pkg::PLAT_MICROSOFT, fnrp_pkg::ENC_MS_UNICODE,
                          16'h0409, DIR_NAME_ID, 51, 930, 0));
    directed.push_back(mk(fnrp_pkg::PLAT_MICROSOFT, fnrp_pkg::ENC_MS_UNICODE,
                          16'h0409, DIR_NAME_ID, 4, 990, 0));
    directed.push_back(mk(fnrp_pkg::PLAT_MICROSOFT, 16'd2, 16'h0409,
                          DIR_NAME_ID, 10, 100, 0));
    directed.push_back(mk(fnrp_pkg::PLAT_UNICODE, 0, 0, 16'd6, 10, 100, 1));
    // Single-record table whose string ends exactly at the table end.
    directed.push_back(mk(fnrp_pkg::PLAT_MICROSOFT, fnrp_pkg::ENC_MS_SYMBOL,
                          16'h0009, DIR_NAME_ID, 50, 930, 1));
    // English Windows records replace the pick, including masked language ids.
    directed.push_back(mk(fnrp_pkg::PLAT_MICROSOFT, fnrp_pkg::ENC_MS_SYMBOL,
                          16'h0412, DIR_NAME_ID, 10, 100, 0));
    directed.push_back(mk(fnrp_pkg::PLAT_MICROSOFT, fnrp_pkg::ENC_MS_UNICODE,
                          16'h0809, DIR_NAME_ID, 10, 100, 0));
    directed.push_back(mk(fnrp_pkg::PLAT_MICROSOFT, fnrp_pkg::ENC_MS_UCS4,
                          16'hFC09, DIR_NAME_ID, 10, 100, 0));
    directed.push_back(mk(fnrp_pkg::PLAT_MAC, 16'd5, fnrp_pkg::LANG_MAC_ENGLISH,
                          DIR_NAME_ID, 10, 100, 0));
    directed.push_back(mk(fnrp_pkg::PLAT_MAC, fnrp_pkg::ENC_MAC_ROMAN, 16'd3,
                          DIR_NAME_ID, 10, 100, 1));
    // Nothing usable at all.
    directed.push_back(mk(fnrp_pkg::PLAT_UNICODE, 0, 0, 16'd0, 0, 0, 1));
    foreach (directed[i]) send_record(directed[i]);
    drain_picks();

    // Random phases; the first few hold the register extremes.
    for (int unsigned k = 0; k < PHASE_COUNT; k++) begin
      case (k)
        0:       set_config(16'd0, 16'd0, 20'd6, 31'd0);
        1:       set_config(16'hFFFF, 16'hFFFF, 20'd786426, 31'h7FFF_FFFF);
        2:       set_config(16'hFFFF, 16'hFFFF, 20'd6, 31'h7FFF_FFFF);
        3:       set_config(16'd0, 16'd0, 20'd6, 31'd70000);
        default: random_config();
      endcase
      send_tables(PHASE_ITEMS);
      // Hold the sender until every pick is out before touching registers.
      drain_picks();
    end

    $display("Checked %0d tables (%0d with a pick) from %0d records over %0d register settings,",
             picks.tables, picks.found_tables, picks.records, phases_run);
    $display("including storage bound edges, every platform and register extremes.");
    if (picks.errors == 0) begin
      $display("font_name_record_picker regression: pass");
    end else begin
      $display("font_name_record_picker regression: fail");
    end
    $finish;
  end

  // Guard against a hang: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("font_name_record_picker regression: fail");
    $finish;
  end

endmodule
